@@ rtl/tcw_pkg.sv @@
// shared types and constants of the text console character writer
`timescale 1ns / 1ps
package tcw_pkg;

	// field widths of the item and result beats
	localparam int OP_W   = 1;
	localparam int CHAR_W = 8;
	localparam int COL_FW = 7;
	localparam int ROW_FW = 5;

	// opcodes
	localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
	localparam logic [OP_W-1:0] OP_READ = 1'b1;

	// character codes
	localparam logic [CHAR_W-1:0] CODE_LF      = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] LAST_CONTROL = 8'd31;
	localparam logic [CHAR_W-1:0] BLANK        = 8'h20;

	// command classes handed from front to back
	typedef enum logic [2:0] {
		CMD_PUT  = 3'd0,
		CMD_LF   = 3'd1,
		CMD_CR   = 3'd2,
		CMD_READ = 3'd3,
		CMD_NOP  = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CHAR_W-1:0] char_code;
		logic [COL_FW-1:0] col;
		logic [ROW_FW-1:0] row;
	} cmd_t;

endpackage

@@ rtl/tcw_front.sv @@
// front end: classifies incoming beats and queues them for the back end
`timescale 1ns / 1ps
module tcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tcw_pkg::OP_W-1:0]    opcode,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::COL_FW-1:0]  read_col,
	input  logic [tcw_pkg::ROW_FW-1:0]  read_row,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output tcw_pkg::cmd_t               cmd
);
	import tcw_pkg::*;

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	cmd_t             in_cmd;
	cmd_t             queue_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	// classify the beat
	always_comb begin
		in_cmd.char_code = char_code;
		in_cmd.col       = read_col;
		in_cmd.row       = read_row;
		if (opcode == OP_READ) begin
			if (read_col < COL_FW'(COLUMNS) && read_row < ROW_FW'(ROWS)) begin
				in_cmd.kind = CMD_READ;
			end else begin
				in_cmd.kind = CMD_NOP;
			end
		end else if (char_code > LAST_CONTROL) begin
			in_cmd.kind = CMD_PUT;
		end else if (char_code == CODE_LF) begin
			in_cmd.kind = CMD_LF;
		end else if (char_code == CODE_CR) begin
			in_cmd.kind = CMD_CR;
		end else begin
			in_cmd.kind = CMD_NOP;
		end
	end

	assign in_ready  = (count_q != CNT_W'(QDEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/tcw_back.sv @@
// back end: cursor, row rotation, per-row fill marks and the character memory
`timescale 1ns / 1ps
module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  tcw_pkg::cmd_t               cmd,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tcw_pkg::COL_FW-1:0]  cursor_col,
	output logic [tcw_pkg::ROW_FW-1:0]  cursor_row,
	output logic [tcw_pkg::CHAR_W-1:0]  cell_char
);
	import tcw_pkg::*;

	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int HW_W  = $clog2(COLUMNS + 1);
	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cur_col_q;
	logic [RW-1:0]     cur_row_q;
	logic [RW-1:0]     top_q;
	logic [HW_W-1:0]   fill_q [ROWS];
	logic              fill_ok_q;
	logic [CHAR_W-1:0] rdata_q;
	logic [CHAR_W-1:0] mem [CELLS];

	logic              out_valid_q;
	logic [CW-1:0]     out_col_q;
	logic [RW-1:0]     out_row_q;
	logic [CHAR_W-1:0] out_cell_q;

	logic              fire;
	logic              is_read;
	logic [RW-1:0]     lrow;
	logic [CW-1:0]     lcol;
	logic [RW:0]       row_sum;
	logic [RW-1:0]     prow;
	logic [AW-1:0]     addr;
	logic              mem_we;
	logic [HW_W-1:0]   fill_cur;
	logic [CW-1:0]     col_n;
	logic [RW-1:0]     row_n;
	logic              scroll;

	assign cmd_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign fire      = cmd_valid && cmd_ready;
	assign is_read   = (cmd.kind == CMD_READ);

	// logical row to physical row through the rotation offset
	always_comb begin
		lrow    = is_read ? cmd.row[RW-1:0] : cur_row_q;
		lcol    = is_read ? cmd.col[CW-1:0] : cur_col_q;
		row_sum = {1'b0, lrow} + {1'b0, top_q};
		if (row_sum >= (RW+1)'(ROWS)) begin
			prow = RW'(row_sum - (RW+1)'(ROWS));
		end else begin
			prow = RW'(row_sum);
		end
		addr     = AW'(prow) * COLS_A + AW'(lcol);
		fill_cur = fill_q[prow];
		mem_we   = fire && (cmd.kind == CMD_PUT);
	end

	// next cursor
	always_comb begin
		col_n  = cur_col_q;
		row_n  = cur_row_q;
		scroll = 1'b0;
		case (cmd.kind)
			CMD_PUT: begin
				if (cur_col_q == CW'(COLUMNS - 1)) begin
					col_n = '0;
					if (cur_row_q == RW'(ROWS - 1)) begin
						scroll = 1'b1;
					end else begin
						row_n = cur_row_q + RW'(1);
					end
				end else begin
					col_n = cur_col_q + CW'(1);
				end
			end
			CMD_LF: begin
				col_n = '0;
				if (cur_row_q == RW'(ROWS - 1)) begin
					scroll = 1'b1;
				end else begin
					row_n = cur_row_q + RW'(1);
				end
			end
			CMD_CR: begin
				col_n = '0;
			end
			default: begin
				col_n = cur_col_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= cmd.char_code;
		end
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			fill_ok_q <= (HW_W'(lcol) < fill_cur);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_cell_q  <= '0;
			for (int i = 0; i < ROWS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (fire) begin
						cur_col_q <= col_n;
						cur_row_q <= row_n;
						out_col_q <= col_n;
						out_row_q <= row_n;
						if (mem_we && HW_W'(cur_col_q) >= fill_cur) begin
							fill_q[prow] <= HW_W'(cur_col_q) + HW_W'(1);
						end
						if (scroll) begin
							// old top row becomes the blank bottom row
							fill_q[top_q] <= '0;
							top_q <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
						end
						if (is_read) begin
							state_q <= ST_READ;
						end else begin
							out_cell_q  <= '0;
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					out_cell_q  <= fill_ok_q ? rdata_q : BLANK;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_col = COL_FW'(out_col_q);
	assign cursor_row = ROW_FW'(out_row_q);
	assign cell_char  = out_cell_q;

endmodule

@@ rtl/text_console_char_writer_top.sv @@
// top level of the text console character writer
`timescale 1ns / 1ps
// Text console engine with a COLUMNS by ROWS character store and a cursor. Each input
// beat is a put (printable bytes written at the cursor, line feed, carriage return,
// other control codes ignored) or a read of one cell; each gives one result beat with
// the cursor after the item and, for a read, the cell byte (zero for puts and for reads
// outside the store). A front end classifies beats into a two-entry queue so input
// keeps flowing while a result waits; the back end executes one command at a time.
// A read passes through a second back-end state, ST_READ, because the single-port
// character memory has registered read data; a put or control item does not need it.
// Scrolling copies no cells: the store is addressed through a rotating top-row offset, and a
// per-row fill mark tells which cells of a row hold written data, so cells beyond it
// read as spaces. Reset is therefore immediate, with no clearing pass over the memory.
module text_console_char_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tcw_pkg::OP_W-1:0]    opcode,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::COL_FW-1:0]  read_col,
	input  logic [tcw_pkg::ROW_FW-1:0]  read_row,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tcw_pkg::COL_FW-1:0]  cursor_col,
	output logic [tcw_pkg::ROW_FW-1:0]  cursor_row,
	output logic [tcw_pkg::CHAR_W-1:0]  cell_char
);
	import tcw_pkg::*;

	// classified command between front and back
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	// front: classification and command queue
	tcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.char_code (char_code),
		.read_col  (read_col),
		.read_row  (read_row),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// back: cursor, store and result register
	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.cell_char  (cell_char)
	);

endmodule
